### design/trs_matrix_compose_defines.svh
// Assertion macros for the checks in trs_matrix_compose.
`ifndef TRS_MATRIX_COMPOSE_DEFINES_SVH
`define TRS_MATRIX_COMPOSE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TRSMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("trsmc: check failed");

`define TRSMC_ASSERT_IN_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("trsmc: reset check failed");

`else

`define TRSMC_ASSERT(lbl, prop)

`define TRSMC_ASSERT_IN_RST(lbl, prop)

`endif

`endif

### design/trsmc_pkg.sv
`timescale 1ns / 1ps

package trsmc_pkg;

  localparam int FracBits     = 16;
  localparam int QuatProdBits = 28;

  localparam int QpW        = 32;
  localparam int QuatW      = 16;
  localparam int QprodW     = 2 * QuatW;
  localparam int RotW       = QprodW + 2;
  localparam int ScaleProdW = RotW + QpW;
  localparam int ScaleRndW  = ScaleProdW - QuatProdBits;
  localparam int PivProdW   = 2 * QpW;
  localparam int TermW      = PivProdW - FracBits;
  localparam int AccW       = TermW + 2;
  localparam int SatInW     = (AccW > ScaleRndW) ? AccW : ScaleRndW;

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIVOT_X = 2'd0,
    CFG_PIVOT_Y = 2'd1,
    CFG_PIVOT_Z = 2'd2
  } trsmc_cfg_e;

  typedef logic signed [QpW-1:0]   trsmc_qp_t;
  typedef logic signed [QuatW-1:0] trsmc_quat_t;

  localparam logic signed [RotW-1:0] RotOne = RotW'(1) << QuatProdBits;

  typedef struct packed {
    trsmc_qp_t [2:0] pos;
    trsmc_qp_t [2:0] scl;
    trsmc_quat_t     w;
    trsmc_quat_t     x;
    trsmc_quat_t     y;
    trsmc_quat_t     z;
  } trsmc_item_t;

  // rot[c][r]: column c, row r, exact in Q.28
  typedef struct packed {
    trsmc_qp_t [2:0]                pos;
    trsmc_qp_t [2:0]                scl;
    logic [2:0][2:0][RotW-1:0]      rot;
  } trsmc_rot_t;

  typedef struct packed {
    trsmc_qp_t [2:0]      pos;
    trsmc_qp_t [2:0][2:0] m;
  } trsmc_mat_t;

  typedef struct packed {
    trsmc_qp_t [2:0][2:0] m;
    trsmc_qp_t [2:0]      t;
  } trsmc_res_t;

  function automatic trsmc_qp_t trsmc_sat32(input logic signed [SatInW-1:0] v);
    trsmc_qp_t res;
    if ((&v[SatInW-1:QpW-1]) || !(|v[SatInW-1:QpW-1])) begin
      res = v[QpW-1:0];
    end else if (v[SatInW-1]) begin
      res = {1'b1, {(QpW-1){1'b0}}};
    end else begin
      res = {1'b0, {(QpW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### design/trsmc_in_if.sv
`timescale 1ns / 1ps

interface trsmc_in_if import trsmc_pkg::*; ();
  logic        valid;
  logic        ready;
  trsmc_qp_t   position_x;
  trsmc_qp_t   position_y;
  trsmc_qp_t   position_z;
  trsmc_quat_t quat_w;
  trsmc_quat_t quat_x;
  trsmc_quat_t quat_y;
  trsmc_quat_t quat_z;
  trsmc_qp_t   scale_x;
  trsmc_qp_t   scale_y;
  trsmc_qp_t   scale_z;

  modport source (
    output valid, position_x, position_y, position_z,
    output quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
    input  ready
  );

  modport sink (
    input  valid, position_x, position_y, position_z,
    input  quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
    output ready
  );
endinterface

### design/trsmc_out_if.sv
`timescale 1ns / 1ps

interface trsmc_out_if import trsmc_pkg::*; ();
  logic      valid;
  logic      ready;
  trsmc_qp_t m_r0c0;
  trsmc_qp_t m_r1c0;
  trsmc_qp_t m_r2c0;
  trsmc_qp_t m_r0c1;
  trsmc_qp_t m_r1c1;
  trsmc_qp_t m_r2c1;
  trsmc_qp_t m_r0c2;
  trsmc_qp_t m_r1c2;
  trsmc_qp_t m_r2c2;
  trsmc_qp_t m_r0c3;
  trsmc_qp_t m_r1c3;
  trsmc_qp_t m_r2c3;

  modport source (
    output valid, m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1,
    output m_r0c2, m_r1c2, m_r2c2, m_r0c3, m_r1c3, m_r2c3,
    input  ready
  );

  modport sink (
    input  valid, m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1,
    input  m_r0c2, m_r1c2, m_r2c2, m_r0c3, m_r1c3, m_r2c3,
    output ready
  );
endinterface

### design/trs_matrix_compose.sv
// Local transform builder: for each transfer on in_i (position, quaternion
// w/x/y/z in Q1.14, per-axis scale, all else Q16.16) one transfer on out_o
// carries the upper 3x4 of T(position) * R(quat) * S(scale) * T(-pivot),
// columns 0..2 the scaled rotation and column 3 the translation, saturated.
// The pivot is written through cfg_we_i / cfg_idx_i / cfg_wdata_i (index 0..2
// for x, y, z); write it only while no transfer is in flight.
// The pipeline is three two-stage units: quaternion products and rotation
// sums, rotation times scale with rounding, pivot products with the
// translation sum. Throughput is one item per cycle while out_o.ready is
// high; each stage holds one item and moves on when the stage after it is
// empty or moving.
// Reset clears every stage valid bit and the pivot to zero.
// When out_o.ready is low the output holds, stages behind it fill, and
// in_i.ready drops only once all six stages hold an item.
`timescale 1ns / 1ps
`include "trs_matrix_compose_defines.svh"

module trs_matrix_compose import trsmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  trsmc_in_if.sink            in_i,
  trsmc_out_if.source         out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [QpW-1:0]      cfg_wdata_i
);

  trsmc_qp_t [2:0] pivot_q;

  trsmc_item_t item;
  trsmc_rot_t  rot_data;
  trsmc_mat_t  mat_data;
  trsmc_res_t  res_data;
  logic        rot_valid, rot_ready;
  logic        mat_valid, mat_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (trsmc_cfg_e'(cfg_idx_i))
        CFG_PIVOT_X: pivot_q[0] <= cfg_wdata_i;
        CFG_PIVOT_Y: pivot_q[1] <= cfg_wdata_i;
        CFG_PIVOT_Z: pivot_q[2] <= cfg_wdata_i;
        default: ; // drop writes beyond the pivot registers
      endcase
    end
  end

  always_comb begin
    item.pos[0] = in_i.position_x;
    item.pos[1] = in_i.position_y;
    item.pos[2] = in_i.position_z;
    item.scl[0] = in_i.scale_x;
    item.scl[1] = in_i.scale_y;
    item.scl[2] = in_i.scale_z;
    item.w      = in_i.quat_w;
    item.x      = in_i.quat_x;
    item.y      = in_i.quat_y;
    item.z      = in_i.quat_z;
  end

  trsmc_rot u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (item),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .out_data_o  (rot_data)
  );

  trsmc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .in_data_i   (rot_data),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .out_data_o  (mat_data)
  );

  trsmc_xlat u_xlat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pivot_i     (pivot_q),
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .in_data_i   (mat_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res_data)
  );

  assign out_o.m_r0c0 = res_data.m[0][0];
  assign out_o.m_r1c0 = res_data.m[0][1];
  assign out_o.m_r2c0 = res_data.m[0][2];
  assign out_o.m_r0c1 = res_data.m[1][0];
  assign out_o.m_r1c1 = res_data.m[1][1];
  assign out_o.m_r2c1 = res_data.m[1][2];
  assign out_o.m_r0c2 = res_data.m[2][0];
  assign out_o.m_r1c2 = res_data.m[2][1];
  assign out_o.m_r2c2 = res_data.m[2][2];
  assign out_o.m_r0c3 = res_data.t[0];
  assign out_o.m_r1c3 = res_data.t[1];
  assign out_o.m_r2c3 = res_data.t[2];

  `TRSMC_ASSERT_IN_RST(a_no_out_in_reset, !rst_ni |-> !out_o.valid)

  `TRSMC_ASSERT(a_ready_when_drained, out_o.ready |-> in_i.ready)

  `TRSMC_ASSERT(a_six_cycle_latency,
    $past(in_i.valid && in_i.ready, 6) && $past(rst_ni, 6) &&
    $past(out_o.ready, 1) && $past(out_o.ready, 2) && $past(out_o.ready, 3) &&
    $past(out_o.ready, 4) && $past(out_o.ready, 5) &&
    $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) &&
    $past(rst_ni, 4) && $past(rst_ni, 5) |-> out_o.valid)

endmodule

### design/trsmc_rot.sv
`timescale 1ns / 1ps

// Two stages: quaternion products, then rotation entries.
module trsmc_rot import trsmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  trsmc_item_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output trsmc_rot_t  out_data_o
);

  logic valid_a_q, valid_b_q;
  logic ready_a, ready_b;

  trsmc_qp_t [2:0] pos_a_q, scl_a_q;
  logic signed [QprodW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;

  logic signed [RotW-1:0] exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
  trsmc_rot_t rot_d, rot_q;

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_a) begin
      pos_a_q <= in_data_i.pos;
      scl_a_q <= in_data_i.scl;
      xx_q    <= $signed(in_data_i.x) * $signed(in_data_i.x);
      yy_q    <= $signed(in_data_i.y) * $signed(in_data_i.y);
      zz_q    <= $signed(in_data_i.z) * $signed(in_data_i.z);
      xy_q    <= $signed(in_data_i.x) * $signed(in_data_i.y);
      xz_q    <= $signed(in_data_i.x) * $signed(in_data_i.z);
      yz_q    <= $signed(in_data_i.y) * $signed(in_data_i.z);
      wx_q    <= $signed(in_data_i.w) * $signed(in_data_i.x);
      wy_q    <= $signed(in_data_i.w) * $signed(in_data_i.y);
      wz_q    <= $signed(in_data_i.w) * $signed(in_data_i.z);
    end
  end

  always_comb begin
    exx = RotW'(xx_q);
    eyy = RotW'(yy_q);
    ezz = RotW'(zz_q);
    exy = RotW'(xy_q);
    exz = RotW'(xz_q);
    eyz = RotW'(yz_q);
    ewx = RotW'(wx_q);
    ewy = RotW'(wy_q);
    ewz = RotW'(wz_q);
    rot_d.pos = pos_a_q;
    rot_d.scl = scl_a_q;
    rot_d.rot[0][0] = RotOne - ((eyy + ezz) <<< 1);
    rot_d.rot[0][1] = (exy + ewz) <<< 1;
    rot_d.rot[0][2] = (exz - ewy) <<< 1;
    rot_d.rot[1][0] = (exy - ewz) <<< 1;
    rot_d.rot[1][1] = RotOne - ((exx + ezz) <<< 1);
    rot_d.rot[1][2] = (eyz + ewx) <<< 1;
    rot_d.rot[2][0] = (exz + ewy) <<< 1;
    rot_d.rot[2][1] = (eyz - ewx) <<< 1;
    rot_d.rot[2][2] = RotOne - ((exx + eyy) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (valid_a_q && ready_b) begin
      rot_q <= rot_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_data_o  = rot_q;

endmodule

### design/trsmc_scale.sv
`timescale 1ns / 1ps

// Two stages: rotation times column scale, then round and saturate to Q16.16.
module trsmc_scale import trsmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  trsmc_rot_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output trsmc_mat_t out_data_o
);

  localparam logic signed [ScaleProdW-1:0] Half = ScaleProdW'(1) << (QuatProdBits - 1);

  logic valid_a_q, valid_b_q;
  logic ready_a, ready_b;

  trsmc_qp_t [2:0]         pos_a_q;
  logic signed [ScaleProdW-1:0] prod_d [3][3];
  logic signed [ScaleProdW-1:0] prod_q [3][3];
  logic signed [ScaleProdW-1:0] rnd [3][3];
  trsmc_mat_t              mat_d, mat_q;

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_d[c][r] = $signed(in_data_i.rot[c][r]) * $signed(in_data_i.scl[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_a) begin
      pos_a_q <= in_data_i.pos;
      prod_q  <= prod_d;
    end
  end

  // Round half up: add half, keep the floor.
  always_comb begin
    mat_d.pos = pos_a_q;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        rnd[c][r]     = prod_q[c][r] + Half;
        mat_d.m[c][r] = trsmc_sat32(SatInW'($signed(rnd[c][r][ScaleProdW-1:QuatProdBits])));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_a_q && ready_b) begin
      mat_q <= mat_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_data_o  = mat_q;

endmodule

### design/trsmc_xlat.sv
`timescale 1ns / 1ps

// Two stages: entries times pivot, then position minus the rounded products.
module trsmc_xlat import trsmc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trsmc_qp_t [2:0] pivot_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  trsmc_mat_t      in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output trsmc_res_t      out_data_o
);

  localparam logic signed [PivProdW-1:0] Half = PivProdW'(1) << (FracBits - 1);

  logic valid_a_q, valid_b_q;
  logic ready_a, ready_b;

  trsmc_mat_t                 mat_a_q;
  logic signed [PivProdW-1:0] pp_d [3][3];
  logic signed [PivProdW-1:0] pp_q [3][3];
  logic signed [PivProdW-1:0] rnd [3][3];
  logic signed [AccW-1:0]     acc [3];
  trsmc_res_t                 res_d, res_q;

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  // pp[r][c]: row r entry of column c times pivot c
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pp_d[r][c] = $signed(in_data_i.m[c][r]) * $signed(pivot_i[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_a) begin
      mat_a_q <= in_data_i;
      pp_q    <= pp_d;
    end
  end

  // Round each term on its own before the sum.
  always_comb begin
    res_d.m = mat_a_q.m;
    for (int r = 0; r < 3; r++) begin
      acc[r] = AccW'($signed(mat_a_q.pos[r]));
      for (int c = 0; c < 3; c++) begin
        rnd[r][c] = pp_q[r][c] + Half;
        acc[r]    = acc[r] - AccW'($signed(rnd[r][c][PivProdW-1:FracBits]));
      end
      res_d.t[r] = trsmc_sat32(SatInW'(acc[r]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_a_q && ready_b) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_data_o  = res_q;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import trsmc_pkg::*;

  localparam int RotFrac       = 28;
  localparam int PosFrac       = 16;
  localparam int WideW         = 96;
  localparam int CycleLimit    = 400000;
  localparam int PhaseCount    = 6;
  localparam int ItemsPerPhase = 100;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  localparam trsmc_qp_t   QpZero       = 32'sh0000_0000;
  localparam trsmc_qp_t   QpOne        = 32'sh0001_0000;
  localparam trsmc_qp_t   QpMax        = 32'sh7fff_ffff;
  localparam trsmc_qp_t   QpMin        = 32'sh8000_0000;
  localparam trsmc_qp_t   QpHalfStep   = 32'sh0400_0000;
  localparam trsmc_quat_t QuatZero     = 16'sh0000;
  localparam trsmc_quat_t QuatOne      = 16'sh4000;
  localparam trsmc_quat_t QuatMax      = 16'sh7fff;
  localparam trsmc_quat_t QuatMin      = 16'sh8000;
  localparam trsmc_quat_t QuatHalfRoot = 16'sd11585;

  typedef logic signed [WideW-1:0] wide_t;
  // order matches the output ports: column-major columns 0..2, then translation
  typedef trsmc_qp_t [11:0] xform_t;

  localparam wide_t SatHigh = (wide_t'(1) <<< 31) - wide_t'(1);
  localparam wide_t SatLow  = -(wide_t'(1) <<< 31);

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [QpW-1:0] cfg_wdata_i;

  trsmc_in_if  in_if ();
  trsmc_out_if out_if ();

  trs_matrix_compose DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  trsmc_item_t     pend_q [$];
  xform_t          expected_q [$];
  trsmc_item_t     item_in_flight;
  logic            item_on_bus;
  trsmc_qp_t [2:0] pivot_cfg;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              error_count;
  int              cycle_count;

  string field_name [12] = '{"m_r0c0", "m_r1c0", "m_r2c0", "m_r0c1", "m_r1c1", "m_r2c1",
                             "m_r0c2", "m_r1c2", "m_r2c2", "m_r0c3", "m_r1c3", "m_r2c3"};

  function automatic wide_t shift_round(input wide_t v, input int n);
    return (v + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic trsmc_qp_t clamp_qp(input wide_t v);
    if (v > SatHigh) return QpMax;
    if (v < SatLow) return QpMin;
    return v[31:0];
  endfunction

  function automatic xform_t compose_transform(input trsmc_item_t it,
                                               input trsmc_qp_t [2:0] pivot);
    wide_t     qw, qx, qy, qz, one, acc;
    wide_t     rot [3][3];
    trsmc_qp_t ent [3][3];
    xform_t    res;
    qw  = wide_t'($signed(it.w));
    qx  = wide_t'($signed(it.x));
    qy  = wide_t'($signed(it.y));
    qz  = wide_t'($signed(it.z));
    one = wide_t'(1) <<< RotFrac;
    // products of Q1.14 parts land in Q.28 with no loss
    rot[0][0] = one - 2 * (qy * qy + qz * qz);
    rot[1][0] = 2 * (qx * qy + qw * qz);
    rot[2][0] = 2 * (qx * qz - qw * qy);
    rot[0][1] = 2 * (qx * qy - qw * qz);
    rot[1][1] = one - 2 * (qx * qx + qz * qz);
    rot[2][1] = 2 * (qy * qz + qw * qx);
    rot[0][2] = 2 * (qx * qz + qw * qy);
    rot[1][2] = 2 * (qy * qz - qw * qx);
    rot[2][2] = one - 2 * (qx * qx + qy * qy);
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        ent[r][c] = clamp_qp(shift_round(rot[r][c] * wide_t'($signed(it.scl[c])), RotFrac));
        res[c * 3 + r] = ent[r][c];
      end
    end
    // translation uses the saturated entries, each pivot term rounded alone
    for (int r = 0; r < 3; r++) begin
      acc = wide_t'($signed(it.pos[r]));
      for (int c = 0; c < 3; c++) begin
        acc = acc - shift_round(wide_t'($signed(ent[r][c])) * wide_t'($signed(pivot[c])),
                                PosFrac);
      end
      res[9 + r] = clamp_qp(acc);
    end
    return res;
  endfunction

  function automatic trsmc_qp_t pick_qp();
    trsmc_qp_t v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: v = QpMax;
          1: v = QpMin;
          2: v = QpOne;
          3: v = -QpOne;
          4: v = QpZero;
          default: v = -1;
        endcase
      end
      default: v = $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
    return v;
  endfunction

  function automatic trsmc_quat_t pick_quat();
    trsmc_quat_t v;
    case ($urandom_range(0, 7))
      0: v = trsmc_quat_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = QuatMax;
          1: v = QuatMin;
          2: v = QuatOne;
          3: v = -QuatOne;
          default: v = QuatZero;
        endcase
      end
      default: v = trsmc_quat_t'($urandom_range(0, 1 << 15) - (1 << 14));
    endcase
    return v;
  endfunction

  function automatic trsmc_item_t make_item(
    input trsmc_qp_t px, input trsmc_qp_t py, input trsmc_qp_t pz,
    input trsmc_quat_t w, input trsmc_quat_t x, input trsmc_quat_t y, input trsmc_quat_t z,
    input trsmc_qp_t sx, input trsmc_qp_t sy, input trsmc_qp_t sz);
    trsmc_item_t it;
    it.pos[0] = px;
    it.pos[1] = py;
    it.pos[2] = pz;
    it.w      = w;
    it.x      = x;
    it.y      = y;
    it.z      = z;
    it.scl[0] = sx;
    it.scl[1] = sy;
    it.scl[2] = sz;
    return it;
  endfunction

  function automatic trsmc_item_t random_item();
    return make_item(pick_qp(), pick_qp(), pick_qp(),
                     pick_quat(), pick_quat(), pick_quat(), pick_quat(),
                     pick_qp(), pick_qp(), pick_qp());
  endfunction

  task automatic queue_item(input trsmc_item_t it);
    pend_q = {pend_q, it};
  endtask

  task automatic queue_directed();
    queue_item(make_item(QpZero, QpZero, QpZero, QuatOne, QuatZero, QuatZero, QuatZero,
                         QpOne, QpOne, QpOne));
    queue_item(make_item(QpMax, QpMin, QpOne, QuatOne, QuatZero, QuatZero, QuatZero,
                         QpOne, QpOne, QpOne));
    queue_item(make_item(QpZero, QpZero, QpZero, QuatZero, QuatZero, QuatZero, QuatZero,
                         QpZero, QpZero, QpZero));
    queue_item(make_item(QpZero, QpZero, QpZero, QuatOne, QuatZero, QuatZero, QuatZero,
                         QpMax, QpMin, QpZero));
    queue_item(make_item(QpOne, QpOne, QpOne, QuatMin, QuatMin, QuatMin, QuatMin,
                         QpMax, QpMax, QpMax));
    queue_item(make_item(QpOne, QpOne, QpOne, QuatMin, QuatMin, QuatMin, QuatMin,
                         QpMin, QpMin, QpMin));
    queue_item(make_item(QpMin, QpMin, QpMin, QuatMax, QuatMax, QuatMax, QuatMax,
                         QpMax, QpMax, QpMax));
    queue_item(make_item(QpMax, QpMax, QpMax, QuatMax, QuatMax, QuatMax, QuatMax,
                         QpMin, QpMin, QpMin));
    // quarter turns about each axis
    queue_item(make_item(QpOne, -QpOne, QpZero, QuatHalfRoot, QuatHalfRoot, QuatZero,
                         QuatZero, QpOne, 2 * QpOne, -QpOne));
    queue_item(make_item(QpZero, QpOne, QpZero, QuatHalfRoot, QuatZero, QuatHalfRoot,
                         QuatZero, QpOne, QpOne, QpOne));
    queue_item(make_item(QpZero, QpZero, QpOne, QuatHalfRoot, QuatZero, QuatZero,
                         QuatHalfRoot, QpOne, QpOne, QpOne));
    // quaternions far from unit length
    queue_item(make_item(QpZero, QpZero, QpZero, QuatMax, QuatZero, QuatZero, QuatZero,
                         QpOne, QpOne, QpOne));
    queue_item(make_item(QpOne, QpOne, QpOne, QuatOne, QuatOne, QuatOne, QuatOne,
                         3 * QpOne, -2 * QpOne, QpOne / 2));
    queue_item(make_item(QpZero, QpZero, QpZero, QuatZero, QuatMin, QuatZero, QuatZero,
                         QpOne, QpOne, QpOne));
    // drive translation into both rails
    queue_item(make_item(QpMax, QpMax, QpMax, QuatZero, QuatZero, QuatZero, QuatMin,
                         -QpOne, -QpOne, -QpOne));
    queue_item(make_item(QpMin, QpMin, QpMin, QuatOne, QuatZero, QuatZero, QuatZero,
                         QpOne, QpOne, QpOne));
    queue_item(make_item(1, -1, 32'sh0000_8000, 16'sd1, -16'sd1, 16'sd2, -16'sd2,
                         QpOne, -QpOne, QpMax));
    queue_item(make_item(QpOne, QpZero, -QpOne, QuatZero, QuatOne, QuatZero, QuatZero,
                         -1, 1, -1));
    // products land exactly on half an LSB, both signs
    queue_item(make_item(QpZero, QpZero, QpZero, QuatZero, 16'sd1, 16'sd1, QuatZero,
                         QpHalfStep, -QpHalfStep, QpHalfStep));
  endtask

  task automatic write_pivot(input logic [CfgIdxW-1:0] idx, input trsmc_qp_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= CFG_PIVOT_Z) pivot_cfg[idx] = value;
  endtask

  task automatic program_pivot(input int phase);
    case (phase)
      0: begin
        write_pivot(CFG_PIVOT_X, QpMax);
        write_pivot(CFG_PIVOT_Y, QpMin);
        write_pivot(CFG_PIVOT_Z, QpOne);
        // spare index must leave the pivot alone
        write_pivot(CfgIdxSpare, $urandom);
      end
      1: begin
        write_pivot(CFG_PIVOT_X, QpZero);
        write_pivot(CFG_PIVOT_Y, QpZero);
        write_pivot(CFG_PIVOT_Z, QpZero);
      end
      2: begin
        write_pivot(CFG_PIVOT_X, QpMin);
        write_pivot(CFG_PIVOT_Y, QpMin);
        write_pivot(CFG_PIVOT_Z, QpMin);
      end
      3: begin
        write_pivot(CFG_PIVOT_X, $urandom);
        write_pivot(CFG_PIVOT_Y, $urandom);
        write_pivot(CFG_PIVOT_Z, $urandom);
        write_pivot(CfgIdxSpare, $urandom);
      end
      4: begin
        write_pivot(CFG_PIVOT_X, QpMax);
        write_pivot(CFG_PIVOT_Y, QpMax);
        write_pivot(CFG_PIVOT_Z, QpMax);
      end
      default: begin
        write_pivot(CFG_PIVOT_X, pick_qp());
        write_pivot(CFG_PIVOT_Y, pick_qp());
        write_pivot(CFG_PIVOT_Z, pick_qp());
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || item_on_bus || expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver: hold each item until its transfer, then load the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_q  = {expected_q, compose_transform(item_in_flight, pivot_cfg)};
        item_on_bus = 1'b0;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_in_flight = pend_q.pop_front();
          item_on_bus    = 1'b1;
          in_if.valid      <= 1'b1;
          in_if.position_x <= item_in_flight.pos[0];
          in_if.position_y <= item_in_flight.pos[1];
          in_if.position_z <= item_in_flight.pos[2];
          in_if.quat_w     <= item_in_flight.w;
          in_if.quat_x     <= item_in_flight.x;
          in_if.quat_y     <= item_in_flight.y;
          in_if.quat_z     <= item_in_flight.z;
          in_if.scale_x    <= item_in_flight.scl[0];
          in_if.scale_y    <= item_in_flight.scl[1];
          in_if.scale_z    <= item_in_flight.scl[2];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each output transfer against the oldest prediction
  always @(posedge clk_i) begin
    xform_t got;
    xform_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got[0]  = out_if.m_r0c0;
        got[1]  = out_if.m_r1c0;
        got[2]  = out_if.m_r2c0;
        got[3]  = out_if.m_r0c1;
        got[4]  = out_if.m_r1c1;
        got[5]  = out_if.m_r2c1;
        got[6]  = out_if.m_r0c2;
        got[7]  = out_if.m_r1c2;
        got[8]  = out_if.m_r2c2;
        got[9]  = out_if.m_r0c3;
        got[10] = out_if.m_r1c3;
        got[11] = out_if.m_r2c3;
        if (expected_q.size() == 0) begin
          $error("out_o transfer with no matrix pending");
          error_count++;
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %0d, got %0d", field_name[i], $signed(want[i]),
                     $signed(got[i]));
              error_count++;
            end
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_PIVOT_X;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.position_x = '0;
    in_if.position_y = '0;
    in_if.position_z = '0;
    in_if.quat_w     = '0;
    in_if.quat_x     = '0;
    in_if.quat_y     = '0;
    in_if.quat_z     = '0;
    in_if.scale_x    = '0;
    in_if.scale_y    = '0;
    in_if.scale_z    = '0;
    out_if.ready     = 1'b0;
    pivot_cfg        = '0;
    item_on_bus      = 1'b0;
    error_count      = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_pivot(p);
      if (p == 0) queue_directed();
      repeat (ItemsPerPhase) queue_item(random_item());
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/trsmc_pkg.sv
design/trsmc_in_if.sv
design/trsmc_out_if.sv
design/trsmc_rot.sv
design/trsmc_scale.sv
design/trsmc_xlat.sv
design/trs_matrix_compose.sv
dv/tb_top.sv
